@@ rtl/ts_packet_pid_demux_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the transport stream PID demux checker
// Immediate-consequent and next-cycle forms, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef TS_PACKET_PID_DEMUX_TOP_MACROS_SVH
`define TS_PACKET_PID_DEMUX_TOP_MACROS_SVH

// same-cycle implication
`define TSPD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tspd port check failed");

// next-cycle implication
`define TSPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tspd port check failed");

`endif

@@ rtl/tspd_pkg.sv @@
// ----------------------------------------------------------------------------
// tspd_pkg
// Shared constants, codes and types of the transport stream PID demux.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tspd_pkg;

   localparam int PID_SLOTS  = 16;
   localparam int SLOT_IDX_W = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
   localparam int PKT_LEN    = 188;
   localparam int PID_W      = 13;
   localparam int CC_W       = 4;
   localparam int SLOT_W     = 4;
   localparam int ENTRY_W    = PID_W + CC_W;

   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(PID_SLOTS - 1);

   localparam logic [7:0] POS_LAST      = 8'(PKT_LEN - 1);
   localparam logic [7:0] ADAPT_MAX     = 8'(PKT_LEN - 5);
   localparam logic [7:0] ADAPT_PCR_MIN = 8'd7;

   // header byte positions
   localparam logic [7:0] POS_HDR1  = 8'd1;
   localparam logic [7:0] POS_HDR2  = 8'd2;
   localparam logic [7:0] POS_HDR3  = 8'd3;
   localparam logic [7:0] POS_ALEN  = 8'd4;
   localparam logic [7:0] POS_AFLAG = 8'd5;

   // bit positions inside header and adaptation flag bytes
   localparam int BIT_PUSI  = 6;
   localparam int BIT_ADAPT = 5;
   localparam int BIT_RAI   = 7;
   localparam int BIT_PCR   = 4;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_STATUS  = 2'd1,
      KIND_EOS     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_CONTINUITY = 3'd1,
      ST_NO_START   = 3'd2,
      ST_ADAPTATION = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SC_IDLE   = 2'd0,
      SC_SCAN   = 2'd1,
      SC_DECIDE = 2'd2
   } scan_state_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [PID_W-1:0]  pid;
      logic              unit_start;
      logic              random_access;
      logic              new_stream;
      logic [7:0]        payload_byte;
      logic              last_of_packet;
   } rsp_item_type;

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic             pusi;
      logic [CC_W-1:0]  cc;
      logic             rai;
   } pkt_hdr_type;

   typedef struct packed {
      logic                  done;
      logic                  fail;
      logic [SLOT_IDX_W-1:0] slot;
   } decide_type;

   // slot index to the 4-bit output field (low bits)
   function automatic logic [SLOT_W-1:0] slot_field(input logic [SLOT_IDX_W-1:0] idx);
      logic [SLOT_IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/tspd_ram.sv @@
// ----------------------------------------------------------------------------
// tspd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/tspd_parser.sv @@
// ----------------------------------------------------------------------------
// tspd_parser
// Packet framing by position, header and adaptation field parsing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tspd_parser
   import tspd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic         command,
   input  wire logic [7:0]   data_byte,
   input  wire decide_type   decide,
   output pkt_hdr_type       hdr,
   output logic              start,
   output logic              item_valid,
   output rsp_item_type      item
);

   logic [7:0]            pos_ff, pos_in;
   logic                  pusi_ff, pusi_in;
   logic [PID_W-1:0]      pid_ff, pid_in;
   logic [CC_W-1:0]       cc_ff, cc_in;
   logic [7:0]            adapt_ff, adapt_in;
   logic                  drop_ff, drop_in;
   logic                  rai_ff, rai_in;
   logic                  pay_on_ff, pay_on_in;
   logic [SLOT_IDX_W-1:0] pkt_slot_ff, pkt_slot_in;
   logic                  adapt_fail;

   always_comb begin
      pos_in      = pos_ff;
      pusi_in     = pusi_ff;
      pid_in      = pid_ff;
      cc_in       = cc_ff;
      adapt_in    = adapt_ff;
      drop_in     = drop_ff;
      rai_in      = rai_ff;
      pay_on_in   = pay_on_ff;
      pkt_slot_in = pkt_slot_ff;
      start       = 1'b0;
      item_valid  = 1'b0;
      item        = '0;
      adapt_fail  = 1'b0;

      if (accept && command) begin
         pos_in     = '0;
         adapt_in   = '0;
         drop_in    = 1'b0;
         pay_on_in  = 1'b0;
         item_valid = 1'b1;
         item.kind  = KIND_EOS;
      end else if (accept) begin
         pos_in = (pos_ff >= POS_LAST) ? 8'd0 : pos_ff + 8'd1;
         if (pos_ff == 8'd0) begin
            pusi_in     = 1'b0;
            pid_in      = '0;
            cc_in       = '0;
            adapt_in    = '0;
            drop_in     = 1'b0;
            rai_in      = 1'b0;
            pkt_slot_in = '0;
            pay_on_in   = 1'b0;
         end else if (drop_ff) begin
            // rest of an errored packet is discarded
         end else if (pos_ff == POS_HDR1) begin
            pusi_in             = data_byte[BIT_PUSI];
            pid_in[PID_W-1:8]   = data_byte[PID_W-9:0];
         end else if (pos_ff == POS_HDR2) begin
            pid_in[7:0] = data_byte;
         end else if (pos_ff == POS_HDR3) begin
            cc_in = data_byte[CC_W-1:0];
            start = !data_byte[BIT_ADAPT];
         end else if (pay_on_ff) begin
            item_valid          = 1'b1;
            item.kind           = KIND_PAYLOAD;
            item.slot           = slot_field(pkt_slot_ff);
            item.pid            = pid_ff;
            item.payload_byte   = data_byte;
            item.last_of_packet = (pos_ff == POS_LAST);
         end else if (pos_ff == POS_ALEN) begin
            if (data_byte > ADAPT_MAX) begin
               adapt_fail = 1'b1;
            end else if (data_byte == 8'd0) begin
               start = 1'b1;
            end else begin
               adapt_in = data_byte;
            end
         end else if (adapt_ff != 8'd0) begin
            if (pos_ff == POS_AFLAG) begin
               rai_in = data_byte[BIT_RAI];
               adapt_fail = data_byte[BIT_PCR] && (adapt_ff < ADAPT_PCR_MIN);
            end
            if (!adapt_fail) begin
               adapt_in = adapt_ff - 8'd1;
               start    = (adapt_ff == 8'd1);
            end
         end

         if (adapt_fail) begin
            drop_in     = 1'b1;
            item_valid  = 1'b1;
            item.kind   = KIND_STATUS;
            item.status = ST_ADAPTATION;
            item.pid    = pid_ff;
         end
      end

      // lookup outcome arrives while no byte is taken
      if (decide.done) begin
         if (decide.fail) begin
            drop_in = 1'b1;
         end else begin
            pay_on_in   = 1'b1;
            pkt_slot_in = decide.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         pusi_ff     <= 1'b0;
         pid_ff      <= '0;
         cc_ff       <= '0;
         adapt_ff    <= '0;
         drop_ff     <= 1'b0;
         rai_ff      <= 1'b0;
         pay_on_ff   <= 1'b0;
         pkt_slot_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         pusi_ff     <= pusi_in;
         pid_ff      <= pid_in;
         cc_ff       <= cc_in;
         adapt_ff    <= adapt_in;
         drop_ff     <= drop_in;
         rai_ff      <= rai_in;
         pay_on_ff   <= pay_on_in;
         pkt_slot_ff <= pkt_slot_in;
      end
   end

   assign hdr.pid  = pid_ff;
   assign hdr.pusi = pusi_ff;
   assign hdr.cc   = cc_ff;
   assign hdr.rai  = rai_ff;

endmodule

`default_nettype wire

@@ rtl/tspd_slot_ctrl.sv @@
// ----------------------------------------------------------------------------
// tspd_slot_ctrl
// PID slot table: sequential lookup over the slot RAM, continuity check,
// unit tracking and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tspd_slot_ctrl
   import tspd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         eos,
   input  wire pkt_hdr_type  hdr,
   input  wire logic         out_free,
   output logic              busy,
   output logic              item_valid,
   output rsp_item_type      item,
   output decide_type        decide
);

   scan_state_type        state_ff, state_in;
   logic [SLOT_IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic                  issue_ff, issue_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [SLOT_IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic                  found_ff, found_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [SLOT_IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [CC_W-1:0]       stored_cc_ff, stored_cc_in;
   logic [PID_SLOTS-1:0]  valid_ff, valid_in;
   logic [PID_SLOTS-1:0]  open_ff, open_in;

   logic [ENTRY_W-1:0]    rd_data;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  wr_en;
   logic [SLOT_IDX_W-1:0] sel;
   logic                  hit, scan_end, full, cc_bad, created, fire;

   tspd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PID_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sel),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   // entry check, one slot per cycle, in the cycle after its read is issued
   assign hit = chk_valid_ff && valid_ff[chk_idx_ff]
             && (rd_data[ENTRY_W-1:CC_W] == hdr.pid);
   assign scan_end = hit || (chk_valid_ff && (chk_idx_ff == LAST_SLOT));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SC_IDLE:   if (start)    state_in = SC_SCAN;
         SC_SCAN:   if (scan_end) state_in = SC_DECIDE;
         SC_DECIDE: if (out_free) state_in = SC_IDLE;
         default:   state_in = SC_IDLE;
      endcase
   end

   // outputs: decision and write-back
   always_comb begin
      created    = !found_ff;
      sel        = found_ff ? hit_idx_ff : free_idx_ff;
      full       = !found_ff && !free_found_ff;
      cc_bad     = found_ff && (CC_W'(stored_cc_ff + 1'b1) != hdr.cc);
      fire       = (state_ff == SC_DECIDE) && out_free;
      busy       = (state_ff != SC_IDLE);
      wr_en      = fire && !full && !cc_bad;
      wr_data    = {hdr.pid, hdr.cc};
      item_valid = fire;
      item       = '0;
      item.kind  = KIND_STATUS;
      item.pid   = hdr.pid;
      decide     = '0;
      decide.done = fire;
      decide.slot = sel;

      if (full) begin
         item.status = ST_TABLE_FULL;
         decide.fail = 1'b1;
      end else if (cc_bad) begin
         item.status = ST_CONTINUITY;
         item.slot   = slot_field(sel);
         decide.fail = 1'b1;
      end else if (!hdr.pusi && (created || !open_ff[sel])) begin
         item.status     = ST_NO_START;
         item.slot       = slot_field(sel);
         item.new_stream = created;
         decide.fail     = 1'b1;
      end else begin
         item.status        = ST_OK;
         item.slot          = slot_field(sel);
         item.unit_start    = hdr.pusi;
         item.random_access = hdr.pusi && hdr.rai;
         item.new_stream    = created;
      end
   end

   // scan bookkeeping and flag updates
   always_comb begin
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      stored_cc_in  = stored_cc_ff;
      valid_in      = valid_ff;
      open_in       = open_ff;

      if (state_ff == SC_IDLE && start) begin
         scan_idx_in   = '0;
         issue_in      = 1'b1;
         found_in      = 1'b0;
         free_found_in = 1'b0;
      end

      if (state_ff == SC_SCAN) begin
         if (issue_ff) begin
            chk_valid_in = 1'b1;
            chk_idx_in   = scan_idx_ff;
            if (scan_idx_ff == LAST_SLOT) begin
               issue_in = 1'b0;
            end else begin
               scan_idx_in = SLOT_IDX_W'(scan_idx_ff + 1'b1);
            end
         end
         if (hit) begin
            found_in     = 1'b1;
            hit_idx_in   = chk_idx_ff;
            stored_cc_in = rd_data[CC_W-1:0];
         end else if (chk_valid_ff && !valid_ff[chk_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      if (wr_en) begin
         valid_in[sel] = 1'b1;
         if (hdr.pusi) begin
            open_in[sel] = 1'b1;
         end else if (created) begin
            open_in[sel] = 1'b0;
         end
      end

      if (eos) begin
         open_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SC_IDLE;
         scan_idx_ff   <= '0;
         issue_ff      <= 1'b0;
         chk_valid_ff  <= 1'b0;
         chk_idx_ff    <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         open_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         issue_ff      <= issue_in;
         chk_valid_ff  <= chk_valid_in;
         chk_idx_ff    <= chk_idx_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         open_ff       <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      stored_cc_ff <= stored_cc_in;
   end

endmodule

`default_nettype wire

@@ rtl/ts_packet_pid_demux_top.sv @@
// ----------------------------------------------------------------------------
// ts_packet_pid_demux_top
// Transport stream PID demultiplexer: header/adaptation parsing, PID slot
// table with continuity check, status and tagged payload stream out.
// ----------------------------------------------------------------------------
// Bytes are framed into 188-byte packets purely by position (no sync check).
// Each request carries one stream byte (req_tuser = 0) or an end-of-stream
// command (req_tuser = 1) that closes all open units and restarts framing.
// Ordinary bytes are accepted back to back while the output register is free.
// The byte that completes the header or adaptation field starts a PID lookup,
// once per packet: the slot RAM has one read port with registered read data
// and is walked one entry per cycle until the PID hits or the last entry is
// checked, and req_tready stays low from that byte until the status has been
// taken into the output register, also while the response side stalls. Every
// packet yields one status response before its payload; an errored packet
// yields only its status and the rest is dropped. Responses sit in a single
// output register that accepts the next request in the cycle it is drained.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ts_packet_pid_demux_top
   import tspd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] command
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [2:0] status, [6:3] slot,
                                         // [19:7] packet_pid, [20] unit_start,
                                         // [21] random_access, [22] new_stream,
                                         // [30:23] payload_byte, [31] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last_of_packet
);

   logic         accept;
   logic         out_free;
   logic         busy;
   logic         start;
   pkt_hdr_type  hdr;
   decide_type   decide;
   logic         p_item_valid, s_item_valid;
   rsp_item_type p_item, s_item;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // output register is free when empty or drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // bytes are held off while a lookup is in flight
   assign req_tready = !busy && out_free;
   assign accept     = req_tvalid && req_tready;

   tspd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_tuser),
      .data_byte  (req_tdata),
      .decide     (decide),
      .hdr        (hdr),
      .start      (start),
      .item_valid (p_item_valid),
      .item       (p_item)
   );

   tspd_slot_ctrl u_slot_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .eos        (accept && req_tuser),
      .hdr        (hdr),
      .out_free   (out_free),
      .busy       (busy),
      .item_valid (s_item_valid),
      .item       (s_item),
      .decide     (decide)
   );

   // parser and slot table never produce in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (p_item_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = p_item;
      end else if (s_item_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = s_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tlast  = rsp_item_ff.last_of_packet;
   assign rsp_tdata  = {1'b0,
                        rsp_item_ff.payload_byte,
                        rsp_item_ff.new_stream,
                        rsp_item_ff.random_access,
                        rsp_item_ff.unit_start,
                        rsp_item_ff.pid,
                        rsp_item_ff.slot,
                        rsp_item_ff.status};

endmodule

`default_nettype wire

@@ rtl/tspd_checker.sv @@
// ----------------------------------------------------------------------------
// tspd_checker
// Port-level checks of the transport stream PID demux, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ts_packet_pid_demux_top_macros.svh"

module tspd_checker
   import tspd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        rsp_tlast
);

   logic       req_fire;
   logic       rsp_stall;
   logic       rsp_payload;
   logic       rsp_eos;
   logic [2:0] rsp_status;
   logic [2:0] rsp_flags;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_payload = rsp_tvalid && (rsp_tuser == KIND_PAYLOAD);
   assign rsp_eos     = rsp_tvalid && (rsp_tuser == KIND_EOS);
   assign rsp_status  = rsp_tdata[2:0];
   assign rsp_flags   = rsp_tdata[22:20];

   `TSPD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}))
   `TSPD_ASSERT_IMP(a_payload_clean, rsp_payload, rsp_status == ST_OK && rsp_flags == 3'b000)
   `TSPD_ASSERT_IMP(a_eos_clean, rsp_eos, rsp_tdata == 32'd0 && !rsp_tlast)
   `TSPD_ASSERT_NEXT(a_eos_answer, req_fire && req_tuser, rsp_eos)
   `TSPD_ASSERT_IMP(a_last_payload, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_PAYLOAD)

endmodule

bind ts_packet_pid_demux_top tspd_checker u_tspd_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: ts_packet_pid_demux_top testbench
// Feeds transport stream bytes and end-of-stream requests, predicts every
// status, payload and end-of-stream response from a behavioral copy of the
// demux, and checks the responses in order under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import tspd_pkg::*;

   localparam logic [7:0]       POS_SYNC       = 8'd0;
   localparam logic [7:0]       SYNC_BYTE      = 8'h47;
   localparam logic [PID_W-1:0] PAT_PID        = 13'h0000;
   localparam logic [PID_W-1:0] MAX_PID        = 13'h1FFF;
   localparam logic [PID_W-1:0] SIDE_PID       = 13'h0ABC;
   localparam int               RANDOM_BYTES   = 100;
   localparam int               QUIET_TAIL     = 40;
   localparam int               WATCHDOG_LIMIT = 1000;
   localparam int               DRAIN_CYCLES   = PID_SLOTS + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   ts_packet_pid_demux_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Demux model state: PID slot table plus per-packet parse state
   // ---------------------------------------------------------------------
   bit              tbl_valid [PID_SLOTS] = '{default: 1'b0};
   bit [PID_W-1:0]  tbl_pid   [PID_SLOTS] = '{default: '0};
   bit [CC_W-1:0]   tbl_cc    [PID_SLOTS] = '{default: '0};
   bit              tbl_open  [PID_SLOTS] = '{default: 1'b0};
   bit [7:0]        pos        = '0;
   bit              hdr_pusi   = 1'b0;
   bit [PID_W-1:0]  hdr_pid    = '0;
   bit              hdr_adapt  = 1'b0;
   bit [CC_W-1:0]   hdr_cc     = '0;
   bit [7:0]        adapt_left = '0;
   bit              dropping   = 1'b0;
   bit              pkt_rai    = 1'b0;
   int              pkt_slot   = 0;
   bit              in_payload = 1'b0;

   rsp_item_type    expected_rsp [$];
   int              mismatches   = 0;
   int              req_count    = 0;
   bit              idle_on      = 1'b1;
   int              stall_left   = 0;
   int              quiet_cycles = 0;

   // errored packet: status only, rest of the packet is discarded
   function automatic bit drop_packet(input status_type st, input int slot, input bit ns,
                                      output rsp_item_type r);
      dropping = 1'b1;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      r.slot = SLOT_W'(slot);
      r.pid = hdr_pid;
      r.new_stream = ns;
      return 1'b1;
   endfunction

   // header and adaptation complete: find or create the slot, check the stream
   function automatic bit lookup_slot(output rsp_item_type r);
      int  hit_idx;
      int  free_idx;
      bit  created;
      hit_idx = -1;
      free_idx = -1;
      created = 1'b0;
      for (int i = 0; i < PID_SLOTS; i++) begin
         if (hit_idx < 0) begin
            if (tbl_valid[i] && tbl_pid[i] == hdr_pid)
               hit_idx = i;
            else if (!tbl_valid[i] && free_idx < 0)
               free_idx = i;
         end
      end
      if (hit_idx < 0) begin
         if (free_idx < 0)
            return drop_packet(ST_TABLE_FULL, 0, 1'b0, r);
         hit_idx = free_idx;
         tbl_valid[hit_idx] = 1'b1;
         tbl_pid[hit_idx] = hdr_pid;
         tbl_open[hit_idx] = 1'b0;
         created = 1'b1;
      end else if (CC_W'(tbl_cc[hit_idx] + 1) != hdr_cc) begin
         return drop_packet(ST_CONTINUITY, hit_idx, 1'b0, r);
      end
      tbl_cc[hit_idx] = hdr_cc;
      if (hdr_pusi)
         tbl_open[hit_idx] = 1'b1;
      else if (!tbl_open[hit_idx])
         return drop_packet(ST_NO_START, hit_idx, created, r);
      pkt_slot = hit_idx;
      in_payload = 1'b1;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = ST_OK;
      r.slot = SLOT_W'(hit_idx);
      r.pid = hdr_pid;
      r.unit_start = hdr_pusi;
      r.random_access = hdr_pusi & pkt_rai;
      r.new_stream = created;
      return 1'b1;
   endfunction

   // one accepted request in, zero or one response out
   function automatic bit demux_predict(input bit cmd, input logic [7:0] b,
                                        output rsp_item_type r);
      bit hit;
      hit = 1'b0;
      r = '0;
      if (cmd) begin
         foreach (tbl_open[i]) tbl_open[i] = 1'b0;
         pos = POS_SYNC;
         adapt_left = '0;
         dropping = 1'b0;
         in_payload = 1'b0;
         r.kind = KIND_EOS;
         return 1'b1;
      end
      if (pos == POS_SYNC) begin
         hdr_pusi = 1'b0;
         hdr_pid = '0;
         hdr_adapt = 1'b0;
         hdr_cc = '0;
         adapt_left = '0;
         dropping = 1'b0;
         pkt_rai = 1'b0;
         pkt_slot = 0;
         in_payload = 1'b0;
      end else if (dropping) begin
         // rest of an errored packet
      end else if (pos == POS_HDR1) begin
         hdr_pusi = b[BIT_PUSI];
         hdr_pid[12:8] = b[4:0];
      end else if (pos == POS_HDR2) begin
         hdr_pid[7:0] = b;
      end else if (pos == POS_HDR3) begin
         hdr_adapt = b[BIT_ADAPT];
         hdr_cc = b[CC_W-1:0];
         if (!hdr_adapt) hit = lookup_slot(r);
      end else if (in_payload) begin
         r.kind = KIND_PAYLOAD;
         r.slot = SLOT_W'(pkt_slot);
         r.pid = hdr_pid;
         r.payload_byte = b;
         r.last_of_packet = (pos == POS_LAST);
         hit = 1'b1;
      end else if (pos == POS_ALEN) begin
         if (b > ADAPT_MAX)
            hit = drop_packet(ST_ADAPTATION, 0, 1'b0, r);
         else if (b == 8'd0)
            hit = lookup_slot(r);
         else
            adapt_left = b;
      end else if (adapt_left != 0) begin
         if (pos == POS_AFLAG) begin
            pkt_rai = b[BIT_RAI];
            if (b[BIT_PCR] && adapt_left < ADAPT_PCR_MIN)
               hit = drop_packet(ST_ADAPTATION, 0, 1'b0, r);
         end
         if (!dropping) begin
            adapt_left = adapt_left - 8'd1;
            if (adapt_left == 0) hit = lookup_slot(r);
         end
      end
      pos = (pos >= POS_LAST) ? POS_SYNC : pos + 8'd1;
      return hit;
   endfunction

   function automatic int slot_of(input logic [PID_W-1:0] pid);
      for (int i = 0; i < PID_SLOTS; i++)
         if (tbl_valid[i] && tbl_pid[i] == pid) return i;
      return -1;
   endfunction

   // continuity counter that the slot expects next (random for an unknown PID)
   function automatic logic [CC_W-1:0] next_cc(input logic [PID_W-1:0] pid);
      int s;
      s = slot_of(pid);
      return (s < 0) ? CC_W'($urandom) : CC_W'(tbl_cc[s] + 1);
   endfunction

   function automatic logic [PID_W-1:0] fresh_pid();
      logic [PID_W-1:0] pid;
      do pid = PID_W'($urandom); while (slot_of(pid) >= 0);
      return pid;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic send_request(input bit cmd, input logic [7:0] data);
      rsp_item_type item;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (demux_predict(cmd, data, item)) expected_rsp.push_back(item);
      req_count++;
   endtask

   // first len bytes of one packet; a short packet is cut off by end of stream
   task automatic send_packet(input logic [PID_W-1:0] pid, input bit pusi,
                              input logic [CC_W-1:0] cc, input bit adapt, input bit pflag,
                              input logic [7:0] alen, input logic [7:0] aflags,
                              input int len);
      logic [7:0] b;
      for (int p = 0; p < len; p++) begin
         b = 8'($urandom);
         case (8'(p))
            POS_SYNC:  if ($urandom_range(0, 3) != 0) b = SYNC_BYTE;
            POS_HDR1:  b = {b[7], pusi, b[5], pid[12:8]};
            POS_HDR2:  b = pid[7:0];
            POS_HDR3:  b = {b[7:6], adapt, pflag, cc};
            POS_ALEN:  if (adapt) b = alen;
            POS_AFLAG: if (adapt && alen != 0) b = aflags;
            default: ;
         endcase
         send_request(1'b0, b);
      end
      if (len < PKT_LEN) send_request(1'b1, 8'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_payload_units();
      // full packet on the association table PID: new slot, last byte marked
      send_packet(PAT_PID, 1'b1, 4'd5, 1'b0, 1'b1, 8'd0, 8'd0, PKT_LEN);
      send_packet(PAT_PID, 1'b0, next_cc(PAT_PID), 1'b0, 1'b1, 8'd0, 8'd0, 8);
      send_packet(MAX_PID, 1'b1, 4'hF, 1'b0, 1'b1, 8'd0, 8'd0, 6);
      // unit closed by end of stream: continuation has no start
      send_packet(PAT_PID, 1'b0, next_cc(PAT_PID), 1'b0, 1'b1, 8'd0, 8'd0, 6);
      send_packet(PAT_PID, 1'b1, next_cc(PAT_PID), 1'b0, 1'b0, 8'd0, 8'd0, 6);
   endtask

   task automatic test_adaptation();
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b1, 8'd1, 8'h80, 10);
      // zero length: random access stays clear, byte 5 is payload
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b1, 8'd0, 8'hFF, 8);
      // adaptation fills the packet: status only
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b0, ADAPT_MAX, 8'hD0, PKT_LEN);
      // random access reported only when the unit starts
      send_packet(MAX_PID, 1'b0, next_cc(MAX_PID), 1'b1, 1'b1, 8'd2, 8'h80, 12);
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b1, ADAPT_MAX + 8'd1, 8'h00, 8);
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b1, 8'hFF, 8'h00, 8);
      // PCR flag with too short a field
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b1, ADAPT_PCR_MIN - 8'd1,
                  8'h10, 12);
      // PCR at minimum length, no payload flag: bytes still pass
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b1, 1'b0, ADAPT_PCR_MIN, 8'h90, 16);
   endtask

   task automatic test_continuity();
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID) + 4'd3, 1'b0, 1'b1, 8'd0, 8'd0, 8);
      // repeated counter is an error too
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID) - 4'd1, 1'b0, 1'b1, 8'd0, 8'd0, 6);
      send_packet(MAX_PID, 1'b1, next_cc(MAX_PID), 1'b0, 1'b1, 8'd0, 8'd0, 6);
   endtask

   task automatic test_new_slot_errors();
      // slot is created even though the packet fails
      send_packet(SIDE_PID, 1'b0, 4'd9, 1'b0, 1'b1, 8'd0, 8'd0, 6);
      send_packet(SIDE_PID, 1'b0, next_cc(SIDE_PID), 1'b0, 1'b1, 8'd0, 8'd0, 6);
      send_packet(SIDE_PID, 1'b1, next_cc(SIDE_PID), 1'b1, 1'b1, 8'd3, 8'h40, 9);
   endtask

   task automatic test_end_of_stream();
      send_packet(PAT_PID, 1'b1, 4'd0, 1'b0, 1'b1, 8'd0, 8'd0, 0);
      send_packet(PAT_PID, 1'b1, 4'd0, 1'b0, 1'b1, 8'd0, 8'd0, 0);
      send_packet(PAT_PID, 1'b1, next_cc(PAT_PID), 1'b0, 1'b1, 8'd0, 8'd0, 2);
      send_packet(PAT_PID, 1'b1, next_cc(PAT_PID), 1'b1, 1'b1, 8'd20, 8'h80, 7);
      send_packet(PAT_PID, 1'b1, next_cc(PAT_PID), 1'b0, 1'b1, 8'd0, 8'd0, 4);
   endtask

   task automatic test_table_full();
      // slots fill lowest first and are never freed
      while (!tbl_valid[PID_SLOTS-1])
         send_packet(fresh_pid(), 1'b1, 4'($urandom), 1'b0, 1'b1, 8'd0, 8'd0, 5);
      send_packet(fresh_pid(), 1'b1, 4'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8);
      send_packet(fresh_pid(), 1'b0, 4'd0, 1'b1, 1'b1, 8'd1, 8'h80, 8);
   endtask

   task automatic test_random_stream();
      int               start;
      int               pick;
      int               s;
      int               len;
      logic [PID_W-1:0] pid;
      bit               pusi;
      logic [CC_W-1:0]  cc;
      bit               adapt;
      logic [7:0]       alen;
      logic [7:0]       aflags;
      start = req_count;
      while (req_count - start < RANDOM_BYTES) begin
         if (req_count - start > RANDOM_BYTES - QUIET_TAIL) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         s = $urandom_range(0, PID_SLOTS - 1);
         pid = tbl_pid[s];
         pusi = tbl_open[s] ? ($urandom_range(0, 3) == 0) : 1'b1;
         cc = next_cc(pid);
         adapt = ($urandom_range(0, 2) == 0);
         alen = 8'($urandom_range(0, 8));
         aflags = 8'($urandom);
         if (alen < ADAPT_PCR_MIN && $urandom_range(0, 3) != 0) aflags[BIT_PCR] = 1'b0;
         if (pick < 70) begin
            // well-formed packet, counter in sequence
         end else if (pick < 80) begin
            cc = cc + CC_W'($urandom_range(1, 15));
            pusi = 1'($urandom_range(0, 1));
         end else if (pick < 85) begin
            pusi = 1'b0;
         end else if (pick < 90) begin
            adapt = 1'b1;
            alen = 8'($urandom_range(ADAPT_MAX + 1, 255));
         end else if (pick < 95) begin
            pid = fresh_pid();
         end
         if (pick >= 95) begin
            repeat ($urandom_range(1, 10)) send_request(1'b0, 8'($urandom));
            send_request(1'b1, 8'($urandom));
         end else begin
            if ($urandom_range(0, 4) == 0)
               len = PKT_LEN;
            else if (adapt)
               len = 5 + alen + $urandom_range(0, 6);
            else
               len = $urandom_range(4, 10);
            send_packet(pid, pusi, cc, adapt, 1'($urandom_range(0, 1)), alen, aflags, len);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_payload_units();
      test_adaptation();
      test_continuity();
      test_new_slot_errors();
      test_end_of_stream();
      test_table_full();
      test_random_stream();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      // stray responses after the last expected one are caught by the response side
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS ts_packet_pid_demux_top");
      else
         $display("FAIL ts_packet_pid_demux_top");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: in-order check and random back-pressure
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with no request pending: kind %0d data %h",
                   rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("status", want.status, rsp_tdata[2:0]);
            check_field("slot", want.slot, rsp_tdata[6:3]);
            check_field("packet_pid", want.pid, rsp_tdata[19:7]);
            check_field("unit_start", want.unit_start, rsp_tdata[20]);
            check_field("random_access", want.random_access, rsp_tdata[21]);
            check_field("new_stream", want.new_stream, rsp_tdata[22]);
            check_field("payload_byte", want.payload_byte, rsp_tdata[30:23]);
            check_field("tdata_pad", 0, rsp_tdata[31]);
            check_field("last_of_packet", want.last_of_packet, rsp_tlast);
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: too long with no request or response accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL ts_packet_pid_demux_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
